// ===== rtl/core/ycl_pkg.sv =====
// Package for the YUV chroma lookup pixel classifier.
// Holds request/response structs, configuration record, register and mode codes.
// No dependencies.
package ycl_pkg;

  localparam int unsigned CHROMA_BITS = 8;
  localparam int unsigned ADDR_BITS   = 2 * CHROMA_BITS;
  localparam int unsigned TABLE_DEPTH = 1 << ADDR_BITS;

  localparam int unsigned PADDR_BITS = 4;
  localparam int unsigned PDATA_BITS = 32;

  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] REG_BINARY_OUTPUT = 2'd0;
  localparam logic [1:0] REG_LUMA_UPPER    = 2'd1;
  localparam logic [1:0] REG_LUMA_LOWER    = 2'd2;

  localparam logic [7:0] UPPER_GATE_RESET = 8'd220;
  localparam logic [7:0] LOWER_GATE_RESET = 8'd20;
  localparam logic [7:0] CLASS_ON         = 8'd255;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  chroma_byte;
    logic [7:0]  luma_byte;
    logic        row_start;
    logic        frame_start;
    logic [15:0] table_index;
    logic [7:0]  table_value;
  } ycl_req_t;

  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] class_full;
    logic [7:0] class_region;
    logic [7:0] table_data;
    logic       is_read;
  } ycl_rsp_t;

  typedef struct packed {
    logic       binary_output;
    logic [7:0] luma_upper_gate;
    logic [7:0] luma_lower_gate;
  } ycl_cfg_t;

endpackage

// ===== rtl/core/yuv_chroma_lut_pixel_classifier.sv =====
// Top level of the YUV chroma lookup pixel classifier.
// Depends on ycl_pkg, ycl_cfg_regs, ycl_chroma_track, ycl_table_mem.
//
// Usage:
//   in_req_i carries one request per accepted in_valid_i/in_ready_o pair:
//   a pixel (mode 0), a table write (mode 1) or a table read (mode 2).
//   Mode 3 is accepted and dropped. Pixels and table reads each give one
//   response on out_rsp_o under out_valid_o/out_ready_i; table writes give
//   none. Pixels return luma plus the two gated classes; reads return the
//   entry in table_data with is_read set.
//   From acceptance to out_valid_o a request passes the synchronous
//   table read, then classification into the output register. One
//   request is taken every cycle while in_ready_o is high; the table read
//   port is used once per pixel or read, and writes land at their
//   acceptance edge, so a following read sees them.
//   When out_ready_i is low the output register and the read stage hold;
//   in_ready_o drops once both are full and rises as soon as the output
//   drains. Reset clears the chroma latches, column parity, pipeline
//   valids and configuration (binary off, gates 220 and 20). The table
//   is not cleared; entries must be written before use.
//   Configuration: APB at byte addresses 0, 4, 8; write only while idle.
module yuv_chroma_lut_pixel_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ycl_pkg::ycl_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ycl_pkg::ycl_rsp_t              out_rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ycl_pkg::PADDR_BITS-1:0] paddr,
  input  logic [ycl_pkg::PDATA_BITS-1:0] pwdata,
  output logic [ycl_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);

  ycl_pkg::ycl_cfg_t cfg;
  ycl_pkg::ycl_rsp_t rsp_d, rsp_q;

  logic                          accept;
  logic                          is_pixel, is_write, is_read;
  logic [ycl_pkg::ADDR_BITS-1:0] pix_addr, raddr;
  logic [7:0]                    entry, cls;
  logic                          s1_valid_q, s1_valid_d;
  logic                          s1_read_q;
  logic [7:0]                    s1_luma_q;
  logic                          out_valid_q, out_valid_d;
  logic                          out_free, s1_move;
  logic                          under_upper, over_lower;

  ycl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = accept && (in_req_i.mode == ycl_pkg::MODE_PIXEL);
  assign is_write   = accept && (in_req_i.mode == ycl_pkg::MODE_WRITE);
  assign is_read    = accept && (in_req_i.mode == ycl_pkg::MODE_READ);

  ycl_chroma_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_i       (is_pixel),
    .chroma_i      (in_req_i.chroma_byte),
    .row_start_i   (in_req_i.row_start),
    .frame_start_i (in_req_i.frame_start),
    .addr_o        (pix_addr)
  );

  assign raddr = is_read ? in_req_i.table_index[ycl_pkg::ADDR_BITS-1:0] : pix_addr;

  ycl_table_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (is_write),
    .waddr_i (in_req_i.table_index[ycl_pkg::ADDR_BITS-1:0]),
    .wdata_i (in_req_i.table_value),
    .re_i    (is_pixel || is_read),
    .raddr_i (raddr),
    .rdata_o (entry)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = is_pixel || is_read;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    if (cfg.binary_output) begin
      cls = (entry > 8'd1) ? ycl_pkg::CLASS_ON : 8'd0;
    end else begin
      cls = entry;
    end
    under_upper = s1_luma_q <= cfg.luma_upper_gate;
    over_lower  = s1_luma_q > cfg.luma_lower_gate;
    rsp_d = '0;
    if (s1_read_q) begin
      rsp_d.table_data = entry;
      rsp_d.is_read    = 1'b1;
    end else begin
      rsp_d.gray         = s1_luma_q;
      rsp_d.class_full   = under_upper ? cls : 8'd0;
      rsp_d.class_region = (under_upper && over_lower) ? cls : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q <= is_read;
      s1_luma_q <= in_req_i.luma_byte;
    end
    if (s1_move) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== rtl/core/ycl_cfg_regs.sv =====
// APB configuration registers: binary mode and the two luma gates.
// Depends on ycl_pkg.
module ycl_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ycl_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [ycl_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [ycl_pkg::PDATA_BITS-1:0]   prdata,
  output logic                             pready,
  output ycl_pkg::ycl_cfg_t                cfg_o
);

  ycl_pkg::ycl_cfg_t cfg_q, cfg_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        ycl_pkg::REG_BINARY_OUTPUT: cfg_d.binary_output   = pwdata[0];
        ycl_pkg::REG_LUMA_UPPER:    cfg_d.luma_upper_gate = pwdata[7:0];
        ycl_pkg::REG_LUMA_LOWER:    cfg_d.luma_lower_gate = pwdata[7:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ycl_pkg::REG_BINARY_OUTPUT: prdata = {31'd0, cfg_q.binary_output};
      ycl_pkg::REG_LUMA_UPPER:    prdata = {24'd0, cfg_q.luma_upper_gate};
      ycl_pkg::REG_LUMA_LOWER:    prdata = {24'd0, cfg_q.luma_lower_gate};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.binary_output   <= 1'b0;
      cfg_q.luma_upper_gate <= ycl_pkg::UPPER_GATE_RESET;
      cfg_q.luma_lower_gate <= ycl_pkg::LOWER_GATE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ycl_chroma_track.sv =====
// Column tracking and U/V latches for the 4:2:2 stream; forms the table address.
// Depends on ycl_pkg.
module ycl_chroma_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pixel_i,
  input  logic [7:0]                    chroma_i,
  input  logic                          row_start_i,
  input  logic                          frame_start_i,
  output logic [ycl_pkg::ADDR_BITS-1:0] addr_o
);

  logic [7:0] u_q, u_d, v_q, v_d;
  logic       odd_q, odd_d;
  logic       col_odd;
  logic [7:0] u_base, v_base;

  always_comb begin
    col_odd = (row_start_i || frame_start_i) ? 1'b0 : odd_q;
    u_base  = frame_start_i ? 8'd0 : u_q;
    v_base  = frame_start_i ? 8'd0 : v_q;
    u_d     = col_odd ? u_base : chroma_i;
    v_d     = col_odd ? chroma_i : v_base;
    odd_d   = !col_odd;
    addr_o  = {u_d[7 -: ycl_pkg::CHROMA_BITS], v_d[7 -: ycl_pkg::CHROMA_BITS]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q   <= 8'd0;
      v_q   <= 8'd0;
      odd_q <= 1'b0;
    end else if (pixel_i) begin
      u_q   <= u_d;
      v_q   <= v_d;
      odd_q <= odd_d;
    end
  end

endmodule

// ===== rtl/core/ycl_table_mem.sv =====
// Chroma class table: one write port, one read port, registered read data.
// Depends on ycl_pkg.
module ycl_table_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ycl_pkg::ADDR_BITS-1:0] waddr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          re_i,
  input  logic [ycl_pkg::ADDR_BITS-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0] mem_q [ycl_pkg::TABLE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
